// ----- rtl/bsa_pkg.sv -----
// bsa_pkg: shared constants and codes for the bitmap slot allocator
// no dependencies; imported by bsa_find_first, bitmap_slot_allocator_top and tb
package bsa_pkg;

  // default number of slots in the map
  localparam int unsigned SLOTS_DEF = 128;

  // widths fixed by the register and payload formats
  localparam int unsigned CNT_W        = 8;
  localparam int unsigned BANK_W       = 16;
  localparam int unsigned HANDLE_W     = 32;
  localparam int unsigned SLOT_FIELD_W = 7;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned ADDR_W       = 3;

  localparam logic [HANDLE_W-1:0] FAIL_HANDLE = '1;

  // request codes
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // register index taken from paddr bit 2
  localparam logic REG_SLOT_COUNT = 1'b0;
  localparam logic REG_BANK_ID    = 1'b1;

endpackage

// ----- rtl/bsa_find_first.sv -----
// bsa_find_first: lowest set bit of the free map, as one-hot and as an index
// depends on bsa_pkg for the default width SLOTS_DEF
module bsa_find_first
  import bsa_pkg::*;
#(
  parameter int unsigned WIDTH = SLOTS_DEF,
  localparam int unsigned IDX_W = $clog2(WIDTH)
) (
  input  logic [WIDTH-1:0] vec_i,
  output logic             found_o,
  output logic [WIDTH-1:0] onehot_o,
  output logic [IDX_W-1:0] idx_o
);

  logic [WIDTH-1:0] low;

  // isolate the lowest set bit with a single carry chain
  assign low      = vec_i & (~vec_i + WIDTH'(1));
  assign found_o  = |vec_i;
  assign onehot_o = low;

  // one-hot to binary: each index bit is an or over independent positions
  always_comb begin
    idx_o = '0;
    for (int i = 0; i < int'(WIDTH); i++) begin
      idx_o = idx_o | (low[i] ? IDX_W'(i) : '0);
    end
  end

endmodule

// ----- rtl/bitmap_slot_allocator_top.sv -----
// bitmap_slot_allocator_top: free-slot bitmap allocator with apb configuration
// depends on bsa_pkg and bsa_find_first
//
// Usage: requests enter on the in channel (req_type_i, handle_in_i) under
// in_valid_i / in_stall_o; each transaction yields exactly one result on the
// out channel (handle_out_o, ok_o, all_free_o, none_free_o) under
// out_valid_o / out_stall_i. An allocate takes the lowest free slot and
// returns {bank_id, slot}; a free sets the slot named in handle_in_i[6:0].
// An accepted request sits in the input register, and from there the
// find-first and map update feed the result register. Throughput is one
// transaction per cycle while the receiver does not stall; the map update
// and the result register load happen at the same edge, so back-to-back
// requests see each other's effect. When the receiver stalls, the result
// holds and the input register holds behind it; in_stall_o rises once both
// are full. Reset empties the pipeline, sets slot_count to 128, bank_id to 0
// and marks every slot free. Writing slot_count over apb reloads the map;
// write it only while no transaction is in flight.
module bitmap_slot_allocator_top
  import bsa_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    req_type_i,
  input  logic [HANDLE_W-1:0]     handle_in_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [HANDLE_W-1:0]     handle_out_o,
  output logic                    ok_o,
  output logic                    all_free_o,
  output logic                    none_free_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [DATA_W-1:0]       pwdata,
  output logic [DATA_W-1:0]       prdata,
  output logic                    pready
);

  localparam int unsigned IDX_W = $clog2(SLOTS);

  // configuration
  logic [CNT_W-1:0]  slot_count_q;
  logic [BANK_W-1:0] bank_id_q;
  logic [SLOTS-1:0]  limit_q, limit_d;
  logic              cfg_wr;

  // pipeline
  logic                    s1_valid_q;
  logic                    s1_req_q;
  logic [SLOT_FIELD_W-1:0] s1_slot_q;
  logic                    out_valid_q;
  logic [HANDLE_W-1:0]     handle_q, handle_d;
  logic                    ok_q, ok_d;
  logic                    all_free_q, none_free_q;
  logic                    out_load, s1_load;

  // map
  logic [SLOTS-1:0] map_q, map_d;
  logic [SLOTS-1:0] set_vec;
  logic             ff_found;
  logic [SLOTS-1:0] ff_onehot;
  logic [IDX_W-1:0] ff_idx;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[2])
      REG_SLOT_COUNT: prdata = DATA_W'(slot_count_q);
      REG_BANK_ID:    prdata = DATA_W'(bank_id_q);
      default:        prdata = '0;
    endcase
  end

  // usable mask from the written count; bits past SLOTS do not exist
  always_comb begin
    for (int i = 0; i < int'(SLOTS); i++) begin
      limit_d[i] = CNT_W'(i) < pwdata[CNT_W-1:0];
    end
  end

  // handshake
  assign out_load   = !out_valid_q || !out_stall_i;
  assign s1_load    = s1_valid_q && out_load;
  assign in_stall_o = s1_valid_q && !out_load;

  bsa_find_first #(
    .WIDTH (SLOTS)
  ) u_find_first (
    .vec_i    (map_q),
    .found_o  (ff_found),
    .onehot_o (ff_onehot),
    .idx_o    (ff_idx)
  );

  always_comb begin
    for (int i = 0; i < int'(SLOTS); i++) begin
      set_vec[i] = (s1_slot_q == SLOT_FIELD_W'(i)) && limit_q[i];
    end
  end

  always_comb begin
    map_d    = map_q;
    handle_d = FAIL_HANDLE;
    ok_d     = 1'b0;
    unique case (s1_req_q)
      REQ_ALLOC: begin
        if (ff_found) begin
          map_d    = map_q & ~ff_onehot;
          handle_d = {bank_id_q, BANK_W'(ff_idx)};
          ok_d     = 1'b1;
        end
      end
      REQ_FREE: begin
        map_d = map_q | set_vec;
        ok_d  = |set_vec;
      end
      default: begin
        map_d = map_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= CNT_W'(SLOTS_DEF);
      bank_id_q    <= '0;
      limit_q      <= '1;
      map_q        <= '1;
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_wr && paddr[2] == REG_SLOT_COUNT) begin
        slot_count_q <= pwdata[CNT_W-1:0];
        limit_q      <= limit_d;
        map_q        <= limit_d;
      end else if (s1_load) begin
        map_q <= map_d;
      end
      if (cfg_wr && paddr[2] == REG_BANK_ID) begin
        bank_id_q <= pwdata[BANK_W-1:0];
      end
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_load) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      s1_req_q  <= req_type_i;
      s1_slot_q <= handle_in_i[SLOT_FIELD_W-1:0];
    end
    if (s1_load) begin
      handle_q    <= handle_d;
      ok_q        <= ok_d;
      all_free_q  <= map_d == limit_q;
      none_free_q <= map_d == '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign handle_out_o = handle_q;
  assign ok_o         = ok_q;
  assign all_free_o   = all_free_q;
  assign none_free_o  = none_free_q;

endmodule

// ----- tb/sv/tb.sv -----
// tb: self-checking testbench for bitmap_slot_allocator_top
// depends on bsa_pkg and the allocator rtl; keeps its own model of the free map
// and checks every result transaction against it under random idling
`timescale 1ns / 1ps

module tb;
  import bsa_pkg::*;

  localparam int unsigned MAP_W = SLOTS_DEF;
  localparam int unsigned RAND_PHASES = 10;
  localparam int unsigned PHASE_ITEMS = 180;
  localparam int unsigned MAX_REPORTS = 20;

  typedef struct packed {
    logic                req_type;
    logic [HANDLE_W-1:0] handle;
  } slot_request_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic                ok;
    logic                all_free;
    logic                none_free;
  } alloc_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                req_type = REQ_ALLOC;
  logic [HANDLE_W-1:0] handle_in = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [HANDLE_W-1:0] handle_out;
  logic                ok;
  logic                all_free;
  logic                none_free;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  bitmap_slot_allocator_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .req_type_i   (req_type),
    .handle_in_i  (handle_in),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .handle_out_o (handle_out),
    .ok_o         (ok),
    .all_free_o   (all_free),
    .none_free_o  (none_free),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk_i = ~clk_i;

  // allocator model state
  logic [CNT_W-1:0]  model_count = CNT_W'(128);
  logic [BANK_W-1:0] model_bank = '0;
  logic [MAP_W-1:0]  model_map = '1;

  slot_request_t request_queue[$];
  alloc_result_t expected_results[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned results_checked = 0;
  int unsigned allocs_ok = 0;
  int unsigned allocs_failed = 0;
  int unsigned frees_ok = 0;
  int unsigned frees_rejected = 0;
  int unsigned settings_used = 0;

  function automatic int unsigned usable_slots();
    return (model_count > MAP_W) ? MAP_W : int'(model_count);
  endfunction

  function automatic logic [MAP_W-1:0] usable_mask();
    int unsigned c;
    c = usable_slots();
    if (c >= MAP_W) return '1;
    return (MAP_W'(1) << c) - MAP_W'(1);
  endfunction

  // applies one request to the model map and returns the result it should give
  function automatic alloc_result_t apply_request(slot_request_t rq);
    alloc_result_t    res;
    logic [MAP_W-1:0] avail;
    logic [6:0]       slot;
    bit               found;
    res.handle = FAIL_HANDLE;
    res.ok = 1'b0;
    found = 1'b0;
    if (rq.req_type == REQ_ALLOC) begin
      avail = model_map & usable_mask();
      for (int i = 0; i < MAP_W; i++) begin
        if (!found && avail[i]) begin
          found = 1'b1;
          model_map[i] = 1'b0;
          res.handle = {model_bank, 16'(i)};
          res.ok = 1'b1;
        end
      end
      if (found) allocs_ok++;
      else allocs_failed++;
    end else begin
      slot = rq.handle[SLOT_FIELD_W-1:0];
      if (int'(slot) < usable_slots()) begin
        model_map[slot] = 1'b1;
        res.ok = 1'b1;
        frees_ok++;
      end else begin
        frees_rejected++;
      end
    end
    res.all_free = (model_map == usable_mask());
    res.none_free = (model_map == '0);
    return res;
  endfunction

  // driver: predict on acceptance, then present the next request or idle
  always @(posedge clk_i or negedge rst_ni) begin : request_driver
    slot_request_t nxt;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        nxt.req_type = req_type;
        nxt.handle = handle_in;
        expected_results.push_back(apply_request(nxt));
      end
      if (!in_valid || !in_stall) begin
        if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = request_queue.pop_front();
          in_valid <= 1'b1;
          req_type <= nxt.req_type;
          handle_in <= nxt.handle;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each accepted result transaction with the oldest prediction
  always @(posedge clk_i) begin : result_monitor
    alloc_result_t want;
    alloc_result_t got;
    if (rst_ni && out_valid && !out_stall) begin
      got = {handle_out, ok, all_free, none_free};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result: handle=%h ok=%b all_free=%b none_free=%b",
                   $time, got.handle, got.ok, got.all_free, got.none_free);
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (got.handle !== want.handle || got.ok !== want.ok ||
            got.all_free !== want.all_free || got.none_free !== want.none_free) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: mismatch: expected handle=%h ok=%b all_free=%b none_free=%b, %s",
                     $time, want.handle, want.ok, want.all_free, want.none_free,
                     $sformatf("got handle=%h ok=%b all_free=%b none_free=%b",
                               got.handle, got.ok, got.all_free, got.none_free));
        end
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic reg_write(logic reg_sel, logic [DATA_W-1:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_sel, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_sel == REG_SLOT_COUNT) begin
      model_count = value[CNT_W-1:0];
      model_map = usable_mask();
    end else begin
      model_bank = value[BANK_W-1:0];
    end
  endtask

  task automatic configure(logic [CNT_W-1:0] count, logic [BANK_W-1:0] bank);
    reg_write(REG_BANK_ID, DATA_W'(bank));
    reg_write(REG_SLOT_COUNT, DATA_W'(count));
    settings_used++;
  endtask

  task automatic push_request(logic rt, logic [HANDLE_W-1:0] h);
    slot_request_t rq;
    rq.req_type = rt;
    rq.handle = h;
    request_queue.push_back(rq);
  endtask

  // wait until every transaction has come back, then let the pipeline settle;
  // checked at the falling edge so the driver's updates have landed
  task automatic drain();
    while (request_queue.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_idling(int unsigned mode);
    case (mode)
      0: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct = 72;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct = 0;
        recv_stall_pct = 72;
      end
      default: begin
        send_idle_pct = 23;
        recv_stall_pct = 23;
      end
    endcase
  endtask

  initial begin : stimulus
    logic [CNT_W-1:0] phase_count[RAND_PHASES];
    int unsigned      phase_alloc_pct[RAND_PHASES];
    logic [BANK_W-1:0] bank;
    logic [HANDLE_W-1:0] h;
    int unsigned      eff;
    phase_count = '{8'd128, 8'd64, 8'd65, 8'd1, 8'd63, 8'd127, 8'd0,
                    CNT_W'($urandom_range(126, 3)), 8'd255, 8'd2};
    phase_alloc_pct = '{90, 70, 55, 75, 65, 90, 50, 60, 85, 50};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_idling(0);

    // reset state: full map of 128, bank 0; upper handle bits must be ignored
    push_request(REQ_ALLOC, 32'h0);
    push_request(REQ_ALLOC, 32'hffff_ffff);
    push_request(REQ_FREE, 32'hffff_ff80);
    push_request(REQ_FREE, 32'h0000_007f);
    push_request(REQ_ALLOC, 32'h5a5a_a5a5);
    drain();

    // small map: exhaust it, fail, out of range, double free
    configure(8'd3, 16'hffff);
    push_request(REQ_ALLOC, 32'h0);
    push_request(REQ_ALLOC, 32'h0);
    push_request(REQ_ALLOC, 32'h0);
    push_request(REQ_ALLOC, 32'h0);
    push_request(REQ_FREE, 32'h0000_0003);
    push_request(REQ_FREE, 32'hffff_ff82);
    push_request(REQ_FREE, 32'h0000_0001);
    push_request(REQ_FREE, 32'h8000_0000);
    push_request(REQ_FREE, 32'h0000_0000);
    push_request(REQ_FREE, 32'h0000_007f);
    drain();

    // zero count: everything fails, map both empty and all free
    configure(8'd0, 16'h0000);
    push_request(REQ_ALLOC, 32'h0);
    push_request(REQ_FREE, 32'h0);
    drain();

    // count above the slot total is clamped
    configure(8'd255, 16'h8001);
    push_request(REQ_ALLOC, 32'h0);
    push_request(REQ_FREE, 32'hffff_ff7f);
    push_request(REQ_FREE, 32'h0);
    drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p % 3)
        0: bank = 16'hffff;
        1: bank = 16'h0000;
        default: bank = BANK_W'($urandom);
      endcase
      configure(phase_count[p], bank);
      eff = usable_slots();
      set_idling(p % 4);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        h = $urandom;
        if ($urandom_range(99) < phase_alloc_pct[p]) begin
          push_request(REQ_ALLOC, h);
        end else begin
          // mostly in-range slots, with random upper bits
          if (eff > 0 && $urandom_range(99) < 85)
            h[SLOT_FIELD_W-1:0] = SLOT_FIELD_W'($urandom_range(eff - 1));
          push_request(REQ_FREE, h);
        end
      end
      drain();
    end

    $display("covered %0d allocations (%0d failed) and %0d frees (%0d rejected)",
             allocs_ok + allocs_failed, allocs_failed, frees_ok + frees_rejected,
             frees_rejected);
    $display("%0d results checked over %0d register settings, %0d mismatches",
             results_checked, settings_used, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
